[sv/ctga_pkg.sv]
// Shared types and constants for the convolution tap gather address generator.
// Used by the controller, the datapath, the top level and the port checker.
package ctga_pkg;

   // Output tile geometry
   localparam int TILE_SLOTS = 32;
   localparam int SLOT_W     = $clog2(TILE_SLOTS);

   // Field widths
   localparam int ADDR_W     = 32;
   localparam int TAP_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_FIELD_W = SLOT_W + ADDR_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // Last slot index of a tile
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TILE_SLOTS - 1);

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WRAP_Q_START = 3'd0,
      CSR_ROW_STEP     = 3'd1,
      CSR_COL_STEP     = 3'd2,
      CSR_COL_END      = 3'd3,
      CSR_TAP_ROW_STEP = 3'd4,
      CSR_TAP_COL_STEP = 3'd5,
      CSR_TAPS_R       = 3'd6,
      CSR_TAPS_S       = 3'd7
   } csr_index_type;

   // Controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // latch a new request and set up its walk
      logic step;    // issue one slot into the output register
      logic finish;  // final slot: advance tap counters, and the tile base after the last tap
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_slot;  // slot counter points at the final slot
      logic rsp_busy;   // output register holds a result not yet taken
   } status_type;

endpackage

[sv/ctga_ctrl.sv]
// Sequencer for the tap gather address generator: accepts one request,
// then steps the datapath through all tile slots. Depends on ctga_pkg.
module ctga_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                rsp_tready,
   input  ctga_pkg::status_type status,
   output logic                req_tready,
   output ctga_pkg::cmd_type   cmd
);

   ctga_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctga_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ctga_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ctga_pkg::ST_WALK;
            end
         end
         ctga_pkg::ST_WALK: begin
            // issue a slot whenever the output register is free or draining
            if (!status.rsp_busy || rsp_tready) begin
               cmd.step = 1'b1;
               if (status.last_slot) begin
                  cmd.finish = 1'b1;
                  state_in   = ctga_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ctga_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[sv/ctga_datapath.sv]
// Datapath for the tap gather address generator: configuration registers,
// p/q walk, tap counters, tile base and the output register. Depends on ctga_pkg.
module ctga_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [ctga_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ctga_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [ctga_pkg::TILE_SLOTS-1:0]       valid_mask,
   input  logic                                  first_of_image,
   input  logic [ctga_pkg::ADDR_W-1:0]           image_start_p,
   input  ctga_pkg::cmd_type                     cmd,
   input  logic                                  rsp_tready,
   output ctga_pkg::status_type                  status,
   output logic                                  rsp_valid,
   output logic [ctga_pkg::SLOT_W-1:0]           rsp_slot,
   output logic                                  rsp_zero_fill,
   output logic [ctga_pkg::ADDR_W-1:0]           rsp_position,
   output logic                                  rsp_last
);

   // Configuration
   logic [ctga_pkg::ADDR_W-1:0] wrap_q_start_ff, row_step_ff, col_step_ff, col_end_ff;
   logic [ctga_pkg::ADDR_W-1:0] tap_row_step_ff, tap_col_step_ff;
   logic [ctga_pkg::TAP_W-1:0]  taps_r_ff, taps_s_ff;

   // Walk and tap state
   logic [ctga_pkg::TILE_SLOTS-1:0] mask_ff, mask_in;
   logic [ctga_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [ctga_pkg::ADDR_W-1:0]     p_ff, p_in, q_ff, q_in, tap_sum_ff, tap_sum_in;
   logic [ctga_pkg::ADDR_W-1:0]     base_p_ff, base_p_in, base_q_ff, base_q_in;
   logic [ctga_pkg::ADDR_W-1:0]     row_off_ff, row_off_in, col_off_ff, col_off_in;
   logic [ctga_pkg::TAP_W-1:0]      row_cnt_ff, row_cnt_in, col_cnt_ff, col_cnt_in;

   // Output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ctga_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                        rsp_zero_ff, rsp_zero_in;
   logic [ctga_pkg::ADDR_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic                        rsp_last_ff, rsp_last_in;

   // Per-slot arithmetic
   logic [ctga_pkg::ADDR_W-1:0] q_step;
   logic                        q_wrap;
   logic [ctga_pkg::TAP_W-1:0]  col_cnt_inc, row_cnt_inc;
   logic                        slot_on;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_q_start_ff <= '0;
         row_step_ff     <= '0;
         col_step_ff     <= ctga_pkg::ADDR_W'(1);
         col_end_ff      <= ctga_pkg::ADDR_W'(1);
         tap_row_step_ff <= '0;
         tap_col_step_ff <= '0;
         taps_r_ff       <= ctga_pkg::TAP_W'(1);
         taps_s_ff       <= ctga_pkg::TAP_W'(1);
      end else if (csr_we) begin
         case (ctga_pkg::csr_index_type'(csr_index))
            ctga_pkg::CSR_WRAP_Q_START: wrap_q_start_ff <= csr_wdata;
            ctga_pkg::CSR_ROW_STEP:     row_step_ff     <= csr_wdata;
            ctga_pkg::CSR_COL_STEP:     col_step_ff     <= csr_wdata;
            ctga_pkg::CSR_COL_END:      col_end_ff      <= csr_wdata;
            ctga_pkg::CSR_TAP_ROW_STEP: tap_row_step_ff <= csr_wdata;
            ctga_pkg::CSR_TAP_COL_STEP: tap_col_step_ff <= csr_wdata;
            ctga_pkg::CSR_TAPS_R:       taps_r_ff       <= csr_wdata[ctga_pkg::TAP_W-1:0];
            ctga_pkg::CSR_TAPS_S:       taps_s_ff       <= csr_wdata[ctga_pkg::TAP_W-1:0];
            default: ;
         endcase
      end
   end

   // Column step and wrap test
   assign q_step      = q_ff + col_step_ff;
   assign q_wrap      = (q_step >= col_end_ff);
   assign col_cnt_inc = col_cnt_ff + ctga_pkg::TAP_W'(1);
   assign row_cnt_inc = row_cnt_ff + ctga_pkg::TAP_W'(1);
   assign slot_on     = mask_ff[slot_ff];

   // Next-state logic
   always_comb begin
      mask_in      = mask_ff;
      slot_in      = slot_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      tap_sum_in   = tap_sum_ff;
      base_p_in    = base_p_ff;
      base_q_in    = base_q_ff;
      row_off_in   = row_off_ff;
      col_off_in   = col_off_ff;
      row_cnt_in   = row_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;

      // new request: start of image reloads base and clears taps
      if (cmd.load) begin
         mask_in = valid_mask;
         slot_in = '0;
         if (first_of_image) begin
            base_p_in  = image_start_p;
            base_q_in  = wrap_q_start_ff;
            row_off_in = '0;
            col_off_in = '0;
            row_cnt_in = '0;
            col_cnt_in = '0;
            p_in       = image_start_p;
            q_in       = wrap_q_start_ff;
            tap_sum_in = '0;
         end else begin
            p_in       = base_p_ff;
            q_in       = base_q_ff;
            tap_sum_in = row_off_ff + col_off_ff;
         end
      end

      // issue one slot and advance the walk
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = slot_ff;
         rsp_zero_in  = !slot_on;
         rsp_pos_in   = slot_on ? (p_ff + q_ff + tap_sum_ff) : '0;
         rsp_last_in  = (slot_ff == ctga_pkg::LAST_SLOT);
         slot_in      = slot_ff + ctga_pkg::SLOT_W'(1);
         if (q_wrap) begin
            q_in = wrap_q_start_ff;
            p_in = p_ff + row_step_ff;
         end else begin
            q_in = q_step;
         end
      end

      // end of item: column tap first, then row tap, then tile base
      if (cmd.finish) begin
         col_cnt_in = col_cnt_inc;
         col_off_in = col_off_ff + tap_col_step_ff;
         if (col_cnt_inc >= taps_s_ff) begin
            col_cnt_in = '0;
            col_off_in = '0;
            row_cnt_in = row_cnt_inc;
            row_off_in = row_off_ff + tap_row_step_ff;
            if (row_cnt_inc >= taps_r_ff) begin
               row_cnt_in = '0;
               row_off_in = '0;
               base_p_in  = p_in;
               base_q_in  = q_in;
            end
         end
      end
   end

   // Control and tap state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         base_p_ff    <= '0;
         base_q_ff    <= '0;
         row_off_ff   <= '0;
         col_off_ff   <= '0;
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         slot_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         base_p_ff    <= base_p_in;
         base_q_ff    <= base_q_in;
         row_off_ff   <= row_off_in;
         col_off_ff   <= col_off_in;
         row_cnt_ff   <= row_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         slot_ff      <= slot_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      tap_sum_ff  <= tap_sum_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_zero_ff <= rsp_zero_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.last_slot = (slot_ff == ctga_pkg::LAST_SLOT);
   assign status.rsp_busy  = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_zero_fill    = rsp_zero_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[sv/conv_tap_gather_address_generator.sv]
// First result: the accept edge loads the walk registers; the first step registers slot 0 into
// the output register once it is free or draining. Throughput: 32 results per request, one
// per cycle while the response stream does not stall; a new request is taken only when idle.
// Reset: synchronous, active high; clears the slot counter, output valid, tap counters, tile base
// and controller state, and restores the register reset values. No clearing pass.
// Depends on ctga_pkg, ctga_ctrl, ctga_datapath.
module conv_tap_gather_address_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ctga_pkg::REQ_TDATA_W-1:0]     req_tdata,   // valid_mask[31:0], image_start_p[63:32]
   input  logic                                 req_tuser,   // first_of_image
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ctga_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // slot[4:0], src_position[36:5], zero pad
   output logic                                 rsp_tuser,   // zero_fill
   output logic                                 rsp_tlast,   // last
   // configuration writes
   input  logic                                 csr_we,
   input  logic [ctga_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ctga_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ctga_pkg::cmd_type           cmd;
   ctga_pkg::status_type        status;
   logic [ctga_pkg::SLOT_W-1:0] rsp_slot;
   logic [ctga_pkg::ADDR_W-1:0] rsp_position;

   ctga_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   ctga_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .valid_mask     (req_tdata[31:0]),
      .first_of_image (req_tuser),
      .image_start_p  (req_tdata[63:32]),
      .cmd            (cmd),
      .rsp_tready     (rsp_tready),
      .status         (status),
      .rsp_valid      (rsp_tvalid),
      .rsp_slot       (rsp_slot),
      .rsp_zero_fill  (rsp_tuser),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_tlast)
   );

   // pack response payload, lowest field first
   assign rsp_tdata = {{ctga_pkg::RSP_PAD_W{1'b0}}, rsp_position, rsp_slot};

endmodule

[sv/ctga_checker.sv]
// Port-level checks for conv_tap_gather_address_generator, bound to the top level.
// Depends on ctga_pkg.
module ctga_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ctga_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // slots of one request come back to back in increasing order
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid &&
      (rsp_tdata[4:0] == 5'($past(rsp_tdata[4:0]) + 5'd1)))
      else $error("slot sequence broken");

   // last marks the final slot only
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[4:0] == ctga_pkg::LAST_SLOT)))
      else $error("last flag does not match final slot");

   // zero fill carries a zero position
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[36:5] == 32'd0))
      else $error("zero fill with nonzero position");

   // ready is low right after a request is accepted, as its walk starts
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during walk");

endmodule

bind conv_tap_gather_address_generator ctga_checker u_ctga_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
